// ===== sv/pepd_pkg.sv =====
`default_nettype none

package pepd_pkg;

    localparam int WORD_W = 16;
    localparam logic [WORD_W-1:0] MAGIC_WORD = 16'h0B47;
    localparam logic [WORD_W-1:0] PARAM_MASK = 16'h007F;

    localparam int NUM_PRESETS_DEF = 7;
    localparam int VALUES_PER_PRESET_DEF = 10;
    localparam int MAX_PACKET_WORDS_DEF = 32;

    localparam int PARAM_PACKET_WORDS = 10;
    localparam int HEAD_WORDS = 4;
    localparam int GROUP_WORDS = 4;

    localparam int DEFAULT_ROWS = 7;
    localparam int DEFAULT_COLS = 10;

    localparam logic [WORD_W-1:0] DEFAULT_PRESETS [DEFAULT_ROWS][DEFAULT_COLS] = '{
        '{16'd122, 16'd163, 16'd980, 16'd411, 16'd2048,
          16'd3077, 16'd1111, 16'd0, 16'(-42), 16'd1792},
        '{16'd184, 16'd163, 16'(-18), 16'd997, 16'd1392,
          16'd3071, 16'(-331), 16'd0, 16'(-204), 16'd1792},
        '{16'd732, 16'd163, 16'(-18), 16'd1351, 16'd2047,
          16'd1535, 16'd3285, 16'd0, 16'd919, 16'd1792},
        '{16'd1094, 16'd163, 16'd925, 16'd693, 16'd2048,
          16'd1536, 16'd4151, 16'd0, 16'd3785, 16'd1792},
        '{16'(-5), 16'd623, 16'd1351, 16'(-116), 16'd1675,
          16'd81, 16'd3797, 16'd0, 16'd4096, 16'd1792},
        '{16'd0, 16'd849, 16'd1359, 16'd614, 16'd1433,
          16'(-651), 16'd3797, 16'd0, 16'(-196), 16'd1792},
        '{16'(-2), 16'd163, 16'd0, 16'(-17), 16'd2059,
          16'd3072, 16'd11, 16'd0, 16'd3, 16'd1792}
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_WRITE,
        ST_PARAM,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_DUMP,
        PH_XY,
        PH_PRESET,
        PH_PARAM
    } phase_t;

    typedef enum logic [1:0] {
        FO_NONE,
        FO_PRESET,
        FO_PARAM
    } follow_t;

    typedef enum logic [1:0] {
        KIND_SET_XY = 2'd0,
        KIND_SET_PRESET = 2'd1,
        KIND_SET_PARAM = 2'd2,
        KIND_REPLY = 2'd3
    } kind_t;

    function automatic logic [WORD_W-1:0] default_value(input logic [3:0] p,
                                                        input logic [3:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        if (p < 4'(DEFAULT_ROWS) && v < 4'(DEFAULT_COLS))
        begin
            r = DEFAULT_PRESETS[p[2:0]][v];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/preset_editor_packet_decoder.sv =====
// Input: words are taken while idle; after the last word of a packet the first result
// passes ST_DECODE and ST_PUSH (for a table dump, ST_READ/ST_WRITE per word before ST_PUSH).
// Flow: input stalls while a packet's results are produced. Streamed words (dump and
// set_preset) each pass ST_READ and ST_WRITE through the registered read of the table or
// packet memory, and each result passes ST_PUSH, which waits while the output is stalled.
// Reset: asynchronous; the preset table reads as the default presets through per-entry valid bits.
`default_nettype none

module preset_editor_packet_decoder #(
    parameter int NUM_PRESETS = pepd_pkg::NUM_PRESETS_DEF,
    parameter int VALUES_PER_PRESET = pepd_pkg::VALUES_PER_PRESET_DEF,
    parameter int MAX_PACKET_WORDS = pepd_pkg::MAX_PACKET_WORDS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                host_valid,
    output logic                                     host_stall,
    input  wire logic signed [pepd_pkg::WORD_W-1:0]  word,
    input  wire logic                                last,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [1:0]                               kind,
    output logic [3:0]                               param_index,
    output logic [2:0]                               preset_a,
    output logic [2:0]                               preset_b,
    output logic [2:0]                               preset_c,
    output logic signed [pepd_pkg::WORD_W-1:0]       word_zero,
    output logic signed [pepd_pkg::WORD_W-1:0]       word_one,
    output logic signed [pepd_pkg::WORD_W-1:0]       word_two,
    output logic signed [pepd_pkg::WORD_W-1:0]       word_three,
    output logic [2:0]                               word_count,
    output logic                                     packet_end,
    output logic                                     run_end
);

    import pepd_pkg::*;

    localparam int REPLY_WORDS = HEAD_WORDS + VALUES_PER_PRESET;
    localparam int BUF_DEPTH = (REPLY_WORDS > PARAM_PACKET_WORDS) ? REPLY_WORDS
                                                                 : PARAM_PACKET_WORDS;
    localparam int TDEPTH = NUM_PRESETS * VALUES_PER_PRESET;
    localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int PADDR_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(MAX_PACKET_WORDS + 1);
    localparam int PIDX_W = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;
    localparam int VIDX_W = (VALUES_PER_PRESET > 1) ? $clog2(VALUES_PER_PRESET) : 1;
    localparam int WIDX_W = $clog2(REPLY_WORDS + 1);

    state_t  state_reg, state_next;
    phase_t  phase_reg, phase_next;
    follow_t follow_reg, follow_next;
    kind_t   kind_reg, kind_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  words_reg, words_next;
    logic [1:0]        slot_reg, slot_next;
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [2:0]        gcount_reg, gcount_next;
    logic              gpkt_end_reg, gpkt_end_next;
    logic              grun_end_reg, grun_end_next;
    logic [3:0]        pi_reg, pi_next;
    logic [PIDX_W-1:0] tgt_a_reg, tgt_a_next;
    logic [PIDX_W-1:0] tgt_b_reg, tgt_b_next;
    logic [PIDX_W-1:0] tgt_c_reg, tgt_c_next;
    logic [WORD_W-1:0] gw_reg [GROUP_WORDS];
    logic [WORD_W-1:0] gw_next [GROUP_WORDS];
    logic [WORD_W-1:0] hdr_reg [PARAM_PACKET_WORDS];
    logic [WORD_W-1:0] hdr_next [PARAM_PACKET_WORDS];
    logic [WORD_W-1:0] pos_x_reg, pos_x_next;
    logic [WORD_W-1:0] pos_y_reg, pos_y_next;
    logic [TDEPTH-1:0] tv_reg, tv_next;

    logic              result_valid_reg, result_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [3:0]        out_pi_reg, out_pi_next;
    logic [2:0]        out_pa_reg, out_pa_next;
    logic [2:0]        out_pb_reg, out_pb_next;
    logic [2:0]        out_pc_reg, out_pc_next;
    logic [WORD_W-1:0] out_word_reg [GROUP_WORDS];
    logic [WORD_W-1:0] out_word_next [GROUP_WORDS];
    logic [2:0]        out_count_reg, out_count_next;
    logic              out_pkt_end_reg, out_pkt_end_next;
    logic              out_run_end_reg, out_run_end_next;

    logic               t_we;
    logic [TADDR_W-1:0] t_waddr;
    logic [WORD_W-1:0]  t_wdata;
    logic [TADDR_W-1:0] t_raddr;
    logic [WORD_W-1:0]  t_rdata;
    logic               p_we;
    logic [PADDR_W-1:0] p_waddr;
    logic [PADDR_W-1:0] p_raddr;
    logic [WORD_W-1:0]  p_rdata;

    logic               accept;
    logic               ofree;
    logic [VIDX_W-1:0]  dump_v;
    logic [TADDR_W-1:0] dump_taddr;
    logic [WORD_W-1:0]  tbl_word;
    logic [WORD_W-1:0]  stream_word;
    logic               last_word;
    logic               magic_ok;
    logic               is_preset;
    logic               is_param;
    logic [PIDX_W-1:0]  tgt_sel;
    logic [WORD_W-1:0]  param_data;

    pepd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TDEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (t_we),
        .wr_addr (t_waddr),
        .wr_data (t_wdata),
        .rd_addr (t_raddr),
        .rd_data (t_rdata)
    );

    pepd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUF_DEPTH)
    ) u_packet (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_waddr),
        .wr_data (word),
        .rd_addr (p_raddr),
        .rd_data (p_rdata)
    );

    assign accept = host_valid && (state_reg == ST_IDLE);
    assign host_stall = (state_reg != ST_IDLE);
    assign ofree = !result_valid_reg || !result_stall;

    assign p_we = accept && (32'(cnt_reg) < BUF_DEPTH);
    assign p_waddr = PADDR_W'(cnt_reg);
    assign p_raddr = PADDR_W'(widx_reg) + PADDR_W'(HEAD_WORDS);

    assign dump_v = (32'(widx_reg) >= HEAD_WORDS)
                    ? VIDX_W'(widx_reg - WIDX_W'(HEAD_WORDS)) : '0;
    assign dump_taddr = TADDR_W'(pidx_reg * VALUES_PER_PRESET) + TADDR_W'(dump_v);
    assign t_raddr = dump_taddr;
    assign tbl_word = tv_reg[dump_taddr] ? t_rdata
                                         : default_value(4'(pidx_reg), 4'(dump_v));

    always_comb
    begin
        stream_word = p_rdata;
        if (phase_reg == PH_DUMP)
        begin
            case (widx_reg)
                WIDX_W'(0): stream_word = MAGIC_WORD;
                WIDX_W'(1): stream_word = pos_x_reg;
                WIDX_W'(2): stream_word = pos_y_reg;
                WIDX_W'(3): stream_word = WORD_W'(pidx_reg);
                default:    stream_word = tbl_word;
            endcase
        end
    end

    assign last_word = (phase_reg == PH_DUMP) ? (32'(widx_reg) == REPLY_WORDS - 1)
                                              : (32'(widx_reg) == VALUES_PER_PRESET - 1);

    assign magic_ok = (hdr_reg[0] == MAGIC_WORD);
    assign is_preset = (32'(words_reg) == REPLY_WORDS) && (hdr_reg[3] < WORD_W'(NUM_PRESETS));
    assign is_param = !is_preset && (32'(words_reg) == PARAM_PACKET_WORDS)
                      && ((hdr_reg[3] & PARAM_MASK) < WORD_W'(VALUES_PER_PRESET))
                      && (hdr_reg[4] < WORD_W'(NUM_PRESETS))
                      && (hdr_reg[5] < WORD_W'(NUM_PRESETS))
                      && (hdr_reg[6] < WORD_W'(NUM_PRESETS));

    always_comb
    begin
        case (pcnt_reg)
            2'd0:
            begin
                tgt_sel = tgt_a_reg;
                param_data = hdr_reg[7];
            end
            2'd1:
            begin
                tgt_sel = tgt_b_reg;
                param_data = hdr_reg[8];
            end
            default:
            begin
                tgt_sel = tgt_c_reg;
                param_data = hdr_reg[9];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        follow_next = follow_reg;
        kind_next = kind_reg;
        cnt_next = cnt_reg;
        words_next = words_reg;
        slot_next = slot_reg;
        pcnt_next = pcnt_reg;
        widx_next = widx_reg;
        pidx_next = pidx_reg;
        gcount_next = gcount_reg;
        gpkt_end_next = gpkt_end_reg;
        grun_end_next = grun_end_reg;
        pi_next = pi_reg;
        tgt_a_next = tgt_a_reg;
        tgt_b_next = tgt_b_reg;
        tgt_c_next = tgt_c_reg;
        gw_next = gw_reg;
        hdr_next = hdr_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        tv_next = tv_reg;
        result_valid_next = result_valid_reg;
        out_kind_next = out_kind_reg;
        out_pi_next = out_pi_reg;
        out_pa_next = out_pa_reg;
        out_pb_next = out_pb_reg;
        out_pc_next = out_pc_reg;
        out_word_next = out_word_reg;
        out_count_next = out_count_reg;
        out_pkt_end_next = out_pkt_end_reg;
        out_run_end_next = out_run_end_reg;
        t_we = 1'b0;
        t_waddr = TADDR_W'(tgt_a_reg * VALUES_PER_PRESET) + TADDR_W'(widx_reg);
        t_wdata = p_rdata;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < PARAM_PACKET_WORDS; i++)
                    begin
                        if (32'(cnt_reg) == i)
                        begin
                            hdr_next[i] = word;
                        end
                    end
                    if (32'(cnt_reg) < MAX_PACKET_WORDS)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        words_next = cnt_next;
                        cnt_next = '0;
                        state_next = ST_DECODE;
                    end
                end
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                pi_next = hdr_reg[3][3:0];
                if (magic_ok && words_reg == CNT_W'(1))
                begin
                    phase_next = PH_DUMP;
                    kind_next = KIND_REPLY;
                    pidx_next = '0;
                    widx_next = '0;
                    slot_next = '0;
                    state_next = ST_READ;
                end
                else if (magic_ok && 32'(words_reg) >= 3)
                begin
                    pos_x_next = hdr_reg[1];
                    pos_y_next = hdr_reg[2];
                    gw_next[0] = hdr_reg[1];
                    gw_next[1] = hdr_reg[2];
                    gcount_next = 3'd2;
                    gpkt_end_next = 1'b1;
                    grun_end_next = !(is_preset || is_param);
                    kind_next = KIND_SET_XY;
                    phase_next = PH_XY;
                    if (is_preset)
                    begin
                        follow_next = FO_PRESET;
                        tgt_a_next = PIDX_W'(hdr_reg[3]);
                    end
                    else if (is_param)
                    begin
                        follow_next = FO_PARAM;
                        tgt_a_next = PIDX_W'(hdr_reg[4]);
                        tgt_b_next = PIDX_W'(hdr_reg[5]);
                        tgt_c_next = PIDX_W'(hdr_reg[6]);
                    end
                    else
                    begin
                        follow_next = FO_NONE;
                    end
                    state_next = ST_PUSH;
                end
            end

            ST_READ:
            begin
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                gw_next[slot_reg] = stream_word;
                if (phase_reg == PH_PRESET)
                begin
                    t_we = 1'b1;
                    tv_next[t_waddr] = 1'b1;
                end
                widx_next = widx_reg + WIDX_W'(1);
                if (slot_reg == 2'd3 || last_word)
                begin
                    gcount_next = 3'(slot_reg) + 3'd1;
                    gpkt_end_next = last_word;
                    grun_end_next = last_word && ((phase_reg == PH_PRESET)
                                    || (32'(pidx_reg) == NUM_PRESETS - 1));
                    slot_next = '0;
                    state_next = ST_PUSH;
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                    state_next = ST_READ;
                end
            end

            ST_PARAM:
            begin
                t_we = 1'b1;
                t_waddr = TADDR_W'(tgt_sel * VALUES_PER_PRESET) + TADDR_W'(pi_reg);
                t_wdata = param_data;
                tv_next[t_waddr] = 1'b1;
                if (pcnt_reg == 2'd2)
                begin
                    gw_next[0] = hdr_reg[7];
                    gw_next[1] = hdr_reg[8];
                    gw_next[2] = hdr_reg[9];
                    gcount_next = 3'd3;
                    gpkt_end_next = 1'b1;
                    grun_end_next = 1'b1;
                    kind_next = KIND_SET_PARAM;
                    phase_next = PH_PARAM;
                    state_next = ST_PUSH;
                end
                else
                begin
                    pcnt_next = pcnt_reg + 2'd1;
                end
            end

            ST_PUSH:
            begin
                if (ofree)
                begin
                    result_valid_next = 1'b1;
                    out_kind_next = kind_reg;
                    out_pi_next = (kind_reg == KIND_SET_PARAM) ? pi_reg : 4'd0;
                    out_pa_next = (kind_reg == KIND_SET_PARAM || kind_reg == KIND_SET_PRESET)
                                  ? 3'(tgt_a_reg) : 3'd0;
                    out_pb_next = (kind_reg == KIND_SET_PARAM) ? 3'(tgt_b_reg) : 3'd0;
                    out_pc_next = (kind_reg == KIND_SET_PARAM) ? 3'(tgt_c_reg) : 3'd0;
                    for (int j = 0; j < GROUP_WORDS; j++)
                    begin
                        out_word_next[j] = (3'(j) < gcount_reg) ? gw_reg[j] : '0;
                    end
                    out_count_next = gcount_reg;
                    out_pkt_end_next = gpkt_end_reg;
                    out_run_end_next = grun_end_reg;

                    state_next = ST_IDLE;
                    if (!gpkt_end_reg)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_XY:
                            begin
                                if (follow_reg == FO_PRESET)
                                begin
                                    kind_next = KIND_SET_PRESET;
                                    phase_next = PH_PRESET;
                                    widx_next = '0;
                                    slot_next = '0;
                                    state_next = ST_READ;
                                end
                                else if (follow_reg == FO_PARAM)
                                begin
                                    pcnt_next = '0;
                                    state_next = ST_PARAM;
                                end
                            end
                            PH_DUMP:
                            begin
                                if (32'(pidx_reg) != NUM_PRESETS - 1)
                                begin
                                    pidx_next = pidx_reg + PIDX_W'(1);
                                    widx_next = '0;
                                    slot_next = '0;
                                    state_next = ST_READ;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_XY;
            follow_reg <= FO_NONE;
            kind_reg <= KIND_SET_XY;
            cnt_reg <= '0;
            slot_reg <= '0;
            pcnt_reg <= '0;
            widx_reg <= '0;
            pidx_reg <= '0;
            gcount_reg <= '0;
            gpkt_end_reg <= 1'b0;
            grun_end_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            tv_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            follow_reg <= follow_next;
            kind_reg <= kind_next;
            cnt_reg <= cnt_next;
            slot_reg <= slot_next;
            pcnt_reg <= pcnt_next;
            widx_reg <= widx_next;
            pidx_reg <= pidx_next;
            gcount_reg <= gcount_next;
            gpkt_end_reg <= gpkt_end_next;
            grun_end_reg <= grun_end_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            tv_reg <= tv_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        pi_reg <= pi_next;
        tgt_a_reg <= tgt_a_next;
        tgt_b_reg <= tgt_b_next;
        tgt_c_reg <= tgt_c_next;
        gw_reg <= gw_next;
        hdr_reg <= hdr_next;
        out_kind_reg <= out_kind_next;
        out_pi_reg <= out_pi_next;
        out_pa_reg <= out_pa_next;
        out_pb_reg <= out_pb_next;
        out_pc_reg <= out_pc_next;
        out_word_reg <= out_word_next;
        out_count_reg <= out_count_next;
        out_pkt_end_reg <= out_pkt_end_next;
        out_run_end_reg <= out_run_end_next;
    end

    assign result_valid = result_valid_reg;
    assign kind = out_kind_reg;
    assign param_index = out_pi_reg;
    assign preset_a = out_pa_reg;
    assign preset_b = out_pb_reg;
    assign preset_c = out_pc_reg;
    assign word_zero = out_word_reg[0];
    assign word_one = out_word_reg[1];
    assign word_two = out_word_reg[2];
    assign word_three = out_word_reg[3];
    assign word_count = out_count_reg;
    assign packet_end = out_pkt_end_reg;
    assign run_end = out_run_end_reg;

endmodule

`default_nettype wire

// ===== sv/pepd_ram.sv =====
`default_nettype none

module pepd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import pepd_pkg::*;

    localparam int NPRE = NUM_PRESETS_DEF;
    localparam int NVAL = VALUES_PER_PRESET_DEF;
    localparam int MAXW = MAX_PACKET_WORDS_DEF;
    localparam int BUF_WORDS = HEAD_WORDS + VALUES_PER_PRESET_DEF;
    localparam int TARGET_ITEMS = 280;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT = 40;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic l;
    } host_item_t;

    typedef struct packed {
        kind_t kind;
        logic [3:0] param_index;
        logic [2:0] preset_a;
        logic [2:0] preset_b;
        logic [2:0] preset_c;
        logic [3:0][WORD_W-1:0] words;
        logic [2:0] word_count;
        logic packet_end;
        logic run_end;
    } preset_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic host_valid = 1'b0;
    logic host_stall;
    logic [WORD_W-1:0] host_word = '0;
    logic host_last = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [1:0] res_kind;
    logic [3:0] res_param_index;
    logic [2:0] res_preset_a;
    logic [2:0] res_preset_b;
    logic [2:0] res_preset_c;
    logic [WORD_W-1:0] res_word_zero;
    logic [WORD_W-1:0] res_word_one;
    logic [WORD_W-1:0] res_word_two;
    logic [WORD_W-1:0] res_word_three;
    logic [2:0] res_word_count;
    logic res_packet_end;
    logic res_run_end;

    host_item_t host_words[$];
    logic [WORD_W-1:0] pkt_body[$];
    preset_result_t due_results[$];

    logic [WORD_W-1:0] presets [NPRE][NVAL];
    logic [WORD_W-1:0] pkt_words [BUF_WORDS];
    logic [WORD_W-1:0] cur_x;
    logic [WORD_W-1:0] cur_y;
    int pkt_len;

    int items_sent = 0;
    int total_items = 0;
    int results_seen = 0;
    int errors = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int next_hold;
    host_item_t next_item;

    preset_editor_packet_decoder i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .host_valid(host_valid),
        .host_stall(host_stall),
        .word(host_word),
        .last(host_last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind(res_kind),
        .param_index(res_param_index),
        .preset_a(res_preset_a),
        .preset_b(res_preset_b),
        .preset_c(res_preset_c),
        .word_zero(res_word_zero),
        .word_one(res_word_one),
        .word_two(res_word_two),
        .word_three(res_word_three),
        .word_count(res_word_count),
        .packet_end(res_packet_end),
        .run_end(res_run_end)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_result_words(input kind_t k, input logic [3:0] pi,
                                      input logic [2:0] a, input logic [2:0] b,
                                      input logic [2:0] c,
                                      input logic [WORD_W-1:0] seq [BUF_WORDS],
                                      input int total);
        preset_result_t r;
        int s;
        int j;
        for (s = 0; s < total; s += GROUP_WORDS)
        begin
            r = '0;
            r.kind = k;
            r.param_index = pi;
            r.preset_a = a;
            r.preset_b = b;
            r.preset_c = c;
            for (j = 0; j < GROUP_WORDS; j++)
            begin
                if (s + j < total)
                begin
                    r.words[j] = seq[s + j];
                end
            end
            r.word_count = 3'((total - s < GROUP_WORDS) ? total - s : GROUP_WORDS);
            r.packet_end = (s + GROUP_WORDS >= total);
            due_results.push_back(r);
        end
    endtask

    task automatic decode_word(input logic [WORD_W-1:0] w, input logic lst);
        logic [WORD_W-1:0] seq [BUF_WORDS];
        preset_result_t r;
        logic [3:0] pi;
        int n;
        int first;
        int i;
        int j;
        if (pkt_len < BUF_WORDS)
        begin
            pkt_words[pkt_len] = w;
        end
        if (pkt_len < MAXW)
        begin
            pkt_len++;
        end
        if (!lst)
        begin
            return;
        end
        n = pkt_len;
        pkt_len = 0;
        if (pkt_words[0] != MAGIC_WORD)
        begin
            return;
        end
        first = due_results.size();
        seq = '{default: '0};
        if (n == 1)
        begin
            for (i = 0; i < NPRE; i++)
            begin
                seq[0] = MAGIC_WORD;
                seq[1] = cur_x;
                seq[2] = cur_y;
                seq[3] = WORD_W'(i);
                for (j = 0; j < NVAL; j++)
                begin
                    seq[HEAD_WORDS + j] = presets[i][j];
                end
                queue_result_words(KIND_REPLY, '0, '0, '0, '0, seq, HEAD_WORDS + NVAL);
            end
        end
        else if (n >= 3)
        begin
            cur_x = pkt_words[1];
            cur_y = pkt_words[2];
            seq[0] = cur_x;
            seq[1] = cur_y;
            queue_result_words(KIND_SET_XY, '0, '0, '0, '0, seq, 2);
            if (n == HEAD_WORDS + NVAL && pkt_words[3] < NPRE)
            begin
                for (j = 0; j < NVAL; j++)
                begin
                    presets[pkt_words[3]][j] = pkt_words[HEAD_WORDS + j];
                    seq[j] = pkt_words[HEAD_WORDS + j];
                end
                queue_result_words(KIND_SET_PRESET, '0, 3'(pkt_words[3]), '0, '0, seq, NVAL);
            end
            else if (n == PARAM_PACKET_WORDS && (pkt_words[3] & PARAM_MASK) < NVAL
                     && pkt_words[4] < NPRE && pkt_words[5] < NPRE && pkt_words[6] < NPRE)
            begin
                pi = 4'(pkt_words[3] & PARAM_MASK);
                presets[pkt_words[4]][pi] = pkt_words[7];
                presets[pkt_words[5]][pi] = pkt_words[8];
                presets[pkt_words[6]][pi] = pkt_words[9];
                seq[0] = pkt_words[7];
                seq[1] = pkt_words[8];
                seq[2] = pkt_words[9];
                queue_result_words(KIND_SET_PARAM, pi, 3'(pkt_words[4]), 3'(pkt_words[5]),
                                   3'(pkt_words[6]), seq, 3);
            end
        end
        if (due_results.size() > first)
        begin
            r = due_results.pop_back();
            r.run_end = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        errors++;
    endtask

    task automatic check_result();
        preset_result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("unexpected result kind", 32'(res_kind), '0);
            return;
        end
        want = due_results.pop_front();
        if (res_kind != want.kind)
            report_mismatch("kind", 32'(res_kind), 32'(want.kind));
        if (res_param_index != want.param_index)
            report_mismatch("param_index", 32'(res_param_index), 32'(want.param_index));
        if (res_preset_a != want.preset_a)
            report_mismatch("preset_a", 32'(res_preset_a), 32'(want.preset_a));
        if (res_preset_b != want.preset_b)
            report_mismatch("preset_b", 32'(res_preset_b), 32'(want.preset_b));
        if (res_preset_c != want.preset_c)
            report_mismatch("preset_c", 32'(res_preset_c), 32'(want.preset_c));
        if (res_word_zero != want.words[0])
            report_mismatch("word_zero", 32'(res_word_zero), 32'(want.words[0]));
        if (res_word_one != want.words[1])
            report_mismatch("word_one", 32'(res_word_one), 32'(want.words[1]));
        if (res_word_two != want.words[2])
            report_mismatch("word_two", 32'(res_word_two), 32'(want.words[2]));
        if (res_word_three != want.words[3])
            report_mismatch("word_three", 32'(res_word_three), 32'(want.words[3]));
        if (res_word_count != want.word_count)
            report_mismatch("word_count", 32'(res_word_count), 32'(want.word_count));
        if (res_packet_end != want.packet_end)
            report_mismatch("packet_end", 32'(res_packet_end), 32'(want.packet_end));
        if (res_run_end != want.run_end)
            report_mismatch("run_end", 32'(res_run_end), 32'(want.run_end));
    endtask

    task automatic flush_packet();
        host_item_t it;
        int i;
        for (i = 0; i < pkt_body.size(); i++)
        begin
            it.w = pkt_body[i];
            it.l = (i == pkt_body.size() - 1);
            host_words.push_back(it);
        end
        pkt_body = {};
    endtask

    function automatic logic [WORD_W-1:0] preset_field();
        return ($urandom_range(0, 9) == 0) ? WORD_W'($urandom) : WORD_W'($urandom_range(0, NPRE - 1));
    endfunction

    task automatic random_packet();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        len = 1;
        pkt_body = {};
        pkt_body.push_back(MAGIC_WORD);
        if (sel < 4)
        begin
            len = 1;
        end
        else if (sel < 12)
        begin
            pkt_body[0] = WORD_W'($urandom);
            len = $urandom_range(1, BUF_WORDS);
        end
        else if (sel < 16)
        begin
            len = 2;
        end
        else if (sel < 30)
        begin
            len = $urandom_range(3, 16);
        end
        else if (sel < 58)
        begin
            len = HEAD_WORDS + NVAL;
            pkt_body.push_back(WORD_W'($urandom));
            pkt_body.push_back(WORD_W'($urandom));
            pkt_body.push_back(preset_field());
        end
        else if (sel < 90)
        begin
            len = PARAM_PACKET_WORDS;
            pkt_body.push_back(WORD_W'($urandom));
            pkt_body.push_back(WORD_W'($urandom));
            if ($urandom_range(0, 4) == 0)
                pkt_body.push_back(WORD_W'($urandom));
            else
                pkt_body.push_back({9'($urandom), 7'($urandom_range(0, NVAL - 1))});
            pkt_body.push_back(preset_field());
            pkt_body.push_back(preset_field());
            pkt_body.push_back(preset_field());
        end
        else
        begin
            len = $urandom_range(MAXW - 2, MAXW + 6);
        end
        while (pkt_body.size() < len)
        begin
            pkt_body.push_back(WORD_W'($urandom));
        end
        flush_packet();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_valid <= 1'b0;
            host_word <= '0;
            host_last <= 1'b0;
            gap_left <= 0;
        end
        else if (!(host_valid && host_stall))
        begin
            if (host_valid)
            begin
                decode_word(host_word, host_last);
                items_sent++;
            end
            if (gap_left > 0)
            begin
                host_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (host_words.size() > 0)
            begin
                next_item = host_words.pop_front();
                host_word <= next_item.w;
                host_last <= next_item.l;
                host_valid <= 1'b1;
                gap_left <= ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
            end
            else
            begin
                host_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_hold = stall_left;
            if (result_valid && !result_stall)
            begin
                check_result();
                results_seen++;
                if (results_seen == HOLD_AT)
                    next_hold = LONG_HOLD;
                else if ((results_seen / 50) % 3 == 1)
                    next_hold = 0;
                else
                    next_hold = $urandom_range(0, 4);
            end
            if (next_hold > 0)
            begin
                result_stall <= 1'b1;
                stall_left <= next_hold - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    initial
    begin
        int i;
        int j;
        for (i = 0; i < NPRE; i++)
        begin
            for (j = 0; j < NVAL; j++)
            begin
                presets[i][j] = (i < DEFAULT_ROWS && j < DEFAULT_COLS) ? DEFAULT_PRESETS[i][j] : '0;
            end
        end
        pkt_words = '{default: '0};
        cur_x = '0;
        cur_y = '0;
        pkt_len = 0;

        // A reply dump of the reset table, a two-word packet that is ignored, a packet
        // without the magic word, and position and preset packets at the word extremes.
        pkt_body = '{MAGIC_WORD};
        flush_packet();
        pkt_body = '{MAGIC_WORD, 16'h1234};
        flush_packet();
        pkt_body = '{~MAGIC_WORD};
        flush_packet();
        pkt_body = '{MAGIC_WORD, 16'h8000, 16'h7FFF};
        flush_packet();
        pkt_body = '{MAGIC_WORD, 16'h7FFF, 16'h8000, 16'd6, 16'h8000, 16'h7FFF, 16'hFFFF,
                     16'h0000, 16'h0001, 16'h5555, 16'hAAAA, 16'hFFFE, 16'h00FF, 16'hFF00};
        flush_packet();
        pkt_body = '{MAGIC_WORD};
        flush_packet();
        while (host_words.size() < TARGET_ITEMS)
        begin
            random_packet();
        end
        total_items = host_words.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent < total_items) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pepd_pkg.sv
sv/pepd_ram.sv
sv/preset_editor_packet_decoder.sv
tb/tb_top.sv
